// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the gelu_chk checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/gelu_pkg.sv =====
// ----------------------------------------------------------------------------
// GELU package
// Widths, coefficients and the tanh table for the GELU (tanh form) pipeline.
// ----------------------------------------------------------------------------
package gelu_pkg;

    // Data format
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;

    // tanh table on [0, 8]
    localparam int TANH_DEPTH = 256;
    localparam int DEPTH_W    = $clog2(TANH_DEPTH + 1);
    localparam int POS_SHIFT  = FRAC_BITS + 3;

    // Table step in unsigned Q.30
    localparam logic [63:0] TANH_STEP = (64'd8 << 30) / 64'(TANH_DEPTH);

    // Coefficients in unsigned Q0.30
    localparam int COEF_SHIFT = 30;
    localparam int C1_W       = 30;
    localparam int C2_W       = 26;
    localparam logic [C1_W-1:0] COEF_C1 = C1_W'(856722024);
    localparam logic [C2_W-1:0] COEF_C2 = C2_W'(48012366);

    // tanh values in unsigned Q1.30
    localparam int T_W = 31;
    localparam logic [T_W-1:0] T_ONE = T_W'(64'd1 << 30);

    // Datapath widths
    localparam int M_W     = DATA_WIDTH;
    localparam int LIM_W   = FRAC_BITS + 4;
    localparam int MC_W    = (M_W < LIM_W) ? M_W : LIM_W;
    localparam int MC_LIM  = 8 << FRAC_BITS;
    localparam int X2_W    = 2 * MC_W - FRAC_BITS;
    localparam int X3_W    = X2_W + MC_W - FRAC_BITS;
    localparam int C2T_W   = X3_W + C2_W - COEF_SHIFT;
    localparam int U_W     = ((MC_W > C2T_W) ? MC_W : C2T_W) + 1;
    localparam int A_W     = U_W + C1_W - COEF_SHIFT;
    localparam int P_W     = A_W + DEPTH_W;
    localparam int IDX_W   = P_W - POS_SHIFT;
    localparam int FACT_W  = T_W + 1;
    localparam int PROD_W  = M_W + FACT_W + 1;
    localparam int YMAG_W  = PROD_W - 31;

    // Output caps on the magnitude
    localparam logic [YMAG_W-1:0] POS_CAP = YMAG_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic [YMAG_W-1:0] NEG_CAP = YMAG_W'(64'd1 << (DATA_WIDTH - 1));

    // Sideband that rides along the pipeline
    typedef struct packed {
        logic           neg;
        logic [M_W-1:0] mag;
    } sb_t;

    typedef logic [T_W-1:0] tanh_tab_t [TANH_DEPTH + 1];

    // Unsigned quotient by restoring shift and subtract
    function automatic logic [63:0] udiv64(logic [63:0] dividend, logic [63:0] divisor);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], dividend[i]};
            if (rem >= {1'b0, divisor})
            begin
                rem    = rem - {1'b0, divisor};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Build the tanh table: series for tanh(h), then the addition formula
    function automatic tanh_tab_t build_tanh_tab();
        tanh_tab_t   tab;
        logic [63:0] one;
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [63:0] h5;
        logic [63:0] h7;
        logic [63:0] h9;
        logic [63:0] th;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] nv;
        one = 64'd1 << 30;
        h   = TANH_STEP;
        h2  = (h * h) >> 30;
        h3  = (h2 * h) >> 30;
        h5  = (h3 * h2) >> 30;
        h7  = (h5 * h2) >> 30;
        h9  = (h7 * h2) >> 30;
        th  = h - udiv64(h3, 64'd3) + udiv64(64'd2 * h5, 64'd15)
              - udiv64(64'd17 * h7, 64'd315) + udiv64(64'd62 * h9, 64'd2835);
        tab[0] = '0;
        for (int k = 0; k < TANH_DEPTH; k++)
        begin
            t   = 64'(tab[k]);
            num = (t + th) << 30;
            den = one + ((t * th) >> 30);
            nv  = udiv64(num, den);
            tab[k + 1] = (nv > one) ? T_ONE : nv[T_W-1:0];
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

// ===== src/gelu_tanh_lut.sv =====
// ----------------------------------------------------------------------------
// GELU tanh lookup
// Two pipeline stages: table read at the argument, then linear interpolation
// and forming of the (1 +/- tanh) factor.
// ----------------------------------------------------------------------------
module gelu_tanh_lut (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [gelu_pkg::A_W-1:0]     arg,
    input  gelu_pkg::sb_t                in_sb,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gelu_pkg::FACT_W-1:0]  factor,
    output gelu_pkg::sb_t                out_sb
);

    localparam int PW  = gelu_pkg::P_W;
    localparam int PS  = gelu_pkg::POS_SHIFT;
    localparam int IW  = gelu_pkg::IDX_W;
    localparam int DW  = gelu_pkg::DEPTH_W;
    localparam int TW  = gelu_pkg::T_W;
    localparam int FW  = gelu_pkg::FACT_W;
    localparam int IPW = TW + PS;

    // Stage controls
    logic v6_reg;
    logic v7_reg;
    logic en6;
    logic en7;

    // Stage 6 signals
    logic [PW-1:0] pos;
    logic [IW-1:0] idx;
    logic          sat;
    logic [DW-1:0] ti_lo;
    logic [DW-1:0] ti_hi;
    logic [TW-1:0] t_lo;
    logic [TW-1:0] t_hi;
    logic [TW-1:0] lo6_reg;
    logic [TW-1:0] diff6_reg;
    logic [PS-1:0] frac6_reg;
    logic          sat6_reg;
    gelu_pkg::sb_t sb6_reg;

    // Stage 7 signals
    logic [IPW-1:0] interp;
    logic [TW-1:0]  t_val;
    logic [FW-1:0]  factor_next;
    logic [FW-1:0]  factor7_reg;
    gelu_pkg::sb_t  sb7_reg;

    // Advance a stage when it is empty or the next one moves
    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign in_ready = en6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en6)
            begin
                v6_reg <= in_valid;
            end
            if (en7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    // Split the table position into entry and fraction
    assign pos   = PW'(arg) * PW'(gelu_pkg::TANH_DEPTH);
    assign idx   = pos[PW-1:PS];
    assign sat   = (idx >= IW'(gelu_pkg::TANH_DEPTH));
    assign ti_lo = sat ? DW'(0) : idx[DW-1:0];
    assign ti_hi = ti_lo + DW'(1);
    assign t_lo  = gelu_pkg::TANH_TAB[ti_lo];
    assign t_hi  = gelu_pkg::TANH_TAB[ti_hi];

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            lo6_reg   <= t_lo;
            diff6_reg <= (t_hi < t_lo) ? TW'(0) : (t_hi - t_lo);
            frac6_reg <= pos[PS-1:0];
            sat6_reg  <= sat;
            sb6_reg   <= in_sb;
        end
    end

    // Interpolate and form the factor
    assign interp = IPW'(diff6_reg) * IPW'(frac6_reg);
    assign t_val  = sat6_reg ? gelu_pkg::T_ONE : (lo6_reg + interp[IPW-1:PS]);

    always_comb
    begin
        if (sb6_reg.neg)
        begin
            factor_next = FW'(gelu_pkg::T_ONE) - FW'(t_val);
        end
        else
        begin
            factor_next = FW'(gelu_pkg::T_ONE) + FW'(t_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            factor7_reg <= factor_next;
            sb7_reg     <= sb6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign factor    = factor7_reg;
    assign out_sb    = sb7_reg;

endmodule

// ===== src/gelu_tanh_activation_top.sv =====
// Depth: 8 register stages, from the input stage to the result register.
// Throughput: one item per cycle while the output is not stalled; each multiplier has a stage of its own.
// A stalled output holds the pipeline; empty stages still fill behind it.
// Reset: rst_n asynchronous, active low; clears all valid bits, no data is flushed.
// ----------------------------------------------------------------------------
// GELU activation, tanh form
// Pipeline: magnitude and clamp, square, cube, argument add, argument scale,
// tanh lookup and interpolation, output product with rounding and saturation.
// ----------------------------------------------------------------------------
module gelu_tanh_activation_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [gelu_pkg::TDATA_W-1:0]   s_axis_tdata,   // [15:0] x_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gelu_pkg::TDATA_W-1:0]   m_axis_tdata    // [15:0] gelu_value
);

    localparam int DW    = gelu_pkg::DATA_WIDTH;
    localparam int FB    = gelu_pkg::FRAC_BITS;
    localparam int MW    = gelu_pkg::M_W;
    localparam int MCW   = gelu_pkg::MC_W;
    localparam int X2W   = gelu_pkg::X2_W;
    localparam int X3W   = gelu_pkg::X3_W;
    localparam int UW    = gelu_pkg::U_W;
    localparam int AW    = gelu_pkg::A_W;
    localparam int FW    = gelu_pkg::FACT_W;
    localparam int PRW   = gelu_pkg::PROD_W;
    localparam int YW    = gelu_pkg::YMAG_W;
    localparam int SQW   = 2 * MCW;
    localparam int CBW   = X2W + MCW;
    localparam int C2PW  = X3W + gelu_pkg::C2_W;
    localparam int C1PW  = UW + gelu_pkg::C1_W;
    localparam int CS    = gelu_pkg::COEF_SHIFT;

    // Valid bits and stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic en1, en2, en3, en4, en5, eno;
    logic lut_in_ready;
    logic lut_out_valid;

    // Stage payloads
    gelu_pkg::sb_t  sb1_reg, sb2_reg, sb3_reg, sb4_reg, sb5_reg;
    gelu_pkg::sb_t  sb7;
    logic [MCW-1:0] mc1_reg, mc2_reg, mc3_reg;
    logic [X2W-1:0] x2_reg;
    logic [X3W-1:0] x3_reg;
    logic [UW-1:0]  u_reg;
    logic [AW-1:0]  a_reg;
    logic [FW-1:0]  factor7;
    logic [DW-1:0]  res_reg;

    // Combinational terms
    logic [DW-1:0]   x_in;
    logic            x_neg;
    logic [MW-1:0]   x_mag;
    logic [MCW-1:0]  x_clamp;
    logic [SQW-1:0]  sq;
    logic [CBW-1:0]  cube;
    logic [C2PW-1:0] c2_prod;
    logic [UW-1:0]   u_next;
    logic [C1PW-1:0] c1_prod;
    logic [PRW-1:0]  prod;
    logic [YW-1:0]   ymag;
    logic [DW-1:0]   res_next;

    // Advance a stage when it is empty or the next one moves
    assign eno = !vo_reg || m_axis_tready;
    assign en5 = !v5_reg || lut_in_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (eno) vo_reg <= lut_out_valid;
        end
    end

    // Stage 1: magnitude and clamp at eight
    assign x_in    = s_axis_tdata[DW-1:0];
    assign x_neg   = x_in[DW-1];
    assign x_mag   = x_neg ? MW'(~x_in + DW'(1)) : MW'(x_in);
    assign x_clamp = (x_mag < MW'(gelu_pkg::MC_LIM)) ? MCW'(x_mag) : MCW'(gelu_pkg::MC_LIM);

    // Stage 2: square
    assign sq = SQW'(mc1_reg) * SQW'(mc1_reg);

    // Stage 3: cube
    assign cube = CBW'(x2_reg) * CBW'(mc2_reg);

    // Stage 4: x + 0.044715 x^3
    assign c2_prod = C2PW'(x3_reg) * C2PW'(gelu_pkg::COEF_C2);
    assign u_next  = UW'(mc3_reg) + UW'(c2_prod[C2PW-1:CS]);

    // Stage 5: scale by sqrt(2/pi)
    assign c1_prod = C1PW'(u_reg) * C1PW'(gelu_pkg::COEF_C1);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sb1_reg.neg <= x_neg;
            sb1_reg.mag <= x_mag;
            mc1_reg     <= x_clamp;
        end
        if (en2)
        begin
            sb2_reg <= sb1_reg;
            mc2_reg <= mc1_reg;
            x2_reg  <= sq[SQW-1:FB];
        end
        if (en3)
        begin
            sb3_reg <= sb2_reg;
            mc3_reg <= mc2_reg;
            x3_reg  <= cube[CBW-1:FB];
        end
        if (en4)
        begin
            sb4_reg <= sb3_reg;
            u_reg   <= u_next;
        end
        if (en5)
        begin
            sb5_reg <= sb4_reg;
            a_reg   <= c1_prod[C1PW-1:CS];
        end
    end

    // Stages 6 and 7: tanh lookup and factor
    gelu_tanh_lut u_lut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_ready  (lut_in_ready),
        .arg       (a_reg),
        .in_sb     (sb5_reg),
        .out_valid (lut_out_valid),
        .out_ready (eno),
        .factor    (factor7),
        .out_sb    (sb7)
    );

    // Stage 8: product, round half away from zero, saturate
    assign prod = PRW'(sb7.mag) * PRW'(factor7) + (PRW'(1) << 30);
    assign ymag = prod[PRW-1:31];

    always_comb
    begin
        if (sb7.neg)
        begin
            res_next = DW'(YW'(0) - ((ymag > gelu_pkg::NEG_CAP) ? gelu_pkg::NEG_CAP : ymag));
        end
        else
        begin
            res_next = DW'((ymag > gelu_pkg::POS_CAP) ? gelu_pkg::POS_CAP : ymag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (eno)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = gelu_pkg::TDATA_W'(res_reg);

endmodule

// ===== src/gelu_chk.sv =====
// ----------------------------------------------------------------------------
// GELU port checker
// Watches the stream ports of the GELU pipeline; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gelu_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [gelu_pkg::TDATA_W-1:0]   s_axis_tdata,   // [15:0] x_value
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [gelu_pkg::TDATA_W-1:0]   m_axis_tdata    // [15:0] gelu_value
);

    localparam int DW = gelu_pkg::DATA_WIDTH;

    // GELU never drops below about -0.17; allow margin
    localparam logic signed [DW-1:0] GELU_FLOOR = -DW'(1 << (gelu_pkg::FRAC_BITS - 2));

    logic signed [DW-1:0] y_val;
    assign y_val = m_axis_tdata[DW-1:0];

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Input backpressure only comes from a stalled output
    `ASSERT_IMPLY(a_stall_src, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // Result stays above the function minimum
    `ASSERT_IMPLY(a_floor, clk, rst_n, m_axis_tvalid, y_val >= GELU_FLOOR)

    // Pipeline comes out of reset empty
    `ASSERT_IMPLY(a_rst_empty, clk, rst_n, $rose(rst_n), !m_axis_tvalid)

endmodule

bind gelu_tanh_activation_top gelu_chk u_gelu_chk (.*);
